// File: hw/rtl/sact_pkg.sv
package sact_pkg;

  // fixed field widths
  localparam int ADDR_W     = 64;
  localparam int BYTES_W    = 4;
  localparam int VICTIM_W   = 2;
  localparam int CNT_W      = 48;
  localparam int LFSR_W     = 32;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [LFSR_W-1:0] LFSR_TAPS     = 32'hD000_0001;
  localparam logic [LFSR_W-1:0] LFSR_SEED_RST = 32'h0000_0001;
  localparam logic [CNT_W-1:0]  CNT_MAX       = {CNT_W{1'b1}};

  // register index, taken from paddr[2]
  localparam logic CFG_IDX_LFSR_SEED = 1'b0;

  // control into the replacement unit
  typedef struct packed {
    logic              load;
    logic [LFSR_W-1:0] seed;
    logic              prep;
    logic              adv;
  } lfsr_ctl_t;

  // one counter update per committed item
  typedef struct packed {
    logic               en;
    logic               is_store;
    logic               miss;
    logic               wb;
    logic [BYTES_W-1:0] nbytes;
  } cnt_upd_t;

  // counter bank contents
  typedef struct packed {
    logic [CNT_W-1:0] rd;
    logic [CNT_W-1:0] rd_miss;
    logic [CNT_W-1:0] wr;
    logic [CNT_W-1:0] wr_miss;
    logic [CNT_W-1:0] bytes_rd;
    logic [CNT_W-1:0] bytes_wr;
    logic [CNT_W-1:0] wb;
  } cnt_set_t;

endpackage

// File: hw/rtl/sact_if.sv
// access item channel
interface sact_req_if;
  logic                           valid;
  logic                           ready;
  logic [sact_pkg::ADDR_W-1:0]    address;
  logic [sact_pkg::BYTES_W-1:0]   access_bytes;
  logic                           is_store;

  modport source (output valid, address, access_bytes, is_store, input ready);
  modport sink   (input valid, address, access_bytes, is_store, output ready);
endinterface

// lookup result channel
interface sact_rsp_if;
  logic                           valid;
  logic                           ready;
  logic                           hit;
  logic [sact_pkg::VICTIM_W-1:0]  victim_way;
  logic                           writeback;
  logic [sact_pkg::CNT_W-1:0]     read_count;
  logic [sact_pkg::CNT_W-1:0]     read_miss_count;
  logic [sact_pkg::CNT_W-1:0]     write_count;
  logic [sact_pkg::CNT_W-1:0]     write_miss_count;
  logic [sact_pkg::CNT_W-1:0]     bytes_read_count;
  logic [sact_pkg::CNT_W-1:0]     bytes_written_count;
  logic [sact_pkg::CNT_W-1:0]     writeback_count;

  modport source (output valid, hit, victim_way, writeback, read_count, read_miss_count,
                  write_count, write_miss_count, bytes_read_count, bytes_written_count,
                  writeback_count, input ready);
  modport sink   (input valid, hit, victim_way, writeback, read_count, read_miss_count,
                  write_count, write_miss_count, bytes_read_count, bytes_written_count,
                  writeback_count, output ready);
endinterface

// File: hw/rtl/set_assoc_cache_tag_model.sv
// tag model of a set-associative write-back cache with random replacement
// in_item carries one access (address, access_bytes, is_store); out_item returns
// hit, victim way, writeback flag and the seven saturating counters after it
// the apb port holds one register, the lfsr seed at byte address 0; writing
// it also reloads the replacement lfsr; pready is tied high
// each item passes ST_IDLE and ST_LOOKUP: on acceptance the tag row of its set
// is read from the tag ram, and in lookup the hit/victim decision is written
// back and the result appears on out_item; the read-then-write of one ram row
// per item means a new item is accepted only once the last has left lookup
// a finished result waits in the output register while the next item is
// accepted; that item is held in lookup until the receiver takes the result
// reset clears counters and output, loads the seed with 1, then runs a
// clearing pass over all SETS rows of the tag ram with in_item.ready low
module set_assoc_cache_tag_model #(
  parameter int SETS       = 64,
  parameter int WAYS       = 4,
  parameter int LINE_BYTES = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  sact_req_if.sink                          in_item,
  sact_rsp_if.source                        out_item,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sact_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [sact_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [sact_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int LSHIFT = $clog2(LINE_BYTES + 1) - 1;
  localparam int LW     = sact_pkg::ADDR_W - LSHIFT;
  localparam int EW     = LW + 2;
  localparam int ROW_W  = WAYS * EW;
  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int VW     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [SET_W-1:0] SET_MASK = SET_W'(SETS - 1);
  localparam logic [SET_W-1:0] SET_LAST = SET_W'(SETS - 1);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOKUP} state_t;

  state_t                        state_r;
  state_t                        state_nxt;
  logic [SET_W-1:0]              clr_cnt_r;
  logic [LW-1:0]                 line_r;
  logic [SET_W-1:0]              set_r;
  logic                          store_r;
  logic [sact_pkg::BYTES_W-1:0]  bytes_r;
  logic                          out_valid_r;
  logic                          hit_r;
  logic [sact_pkg::VICTIM_W-1:0] victim_r;
  logic                          wb_r;
  logic [sact_pkg::LFSR_W-1:0]   seed_r;

  logic                          accept;
  logic                          commit;
  logic                          cfg_wr;
  logic [LW-1:0]                 in_line;
  logic [SET_W-1:0]              in_set;
  logic [ROW_W-1:0]              row_rd;
  logic [ROW_W-1:0]              row_new;
  logic                          ram_we;
  logic [SET_W-1:0]              ram_waddr;
  logic [ROW_W-1:0]              ram_wdata;
  logic                          hit_any;
  logic [VW-1:0]                 hit_way;
  logic [VW-1:0]                 victim;
  logic [VW+1:0]                 victim_ext;
  logic [EW-1:0]                 vic_ent;
  logic                          wb_now;
  sact_pkg::lfsr_ctl_t           lfsr_ctl;
  sact_pkg::cnt_upd_t            cnt_upd;
  sact_pkg::cnt_set_t            cnt;

  // handshakes
  assign in_item.ready = (state_r == ST_IDLE);
  assign accept        = in_item.valid && (state_r == ST_IDLE);
  assign commit        = (state_r == ST_LOOKUP) && (!out_valid_r || out_item.ready);
  assign cfg_wr        = psel && penable && pwrite;

  // line address and set of the incoming access
  assign in_line = in_item.address[sact_pkg::ADDR_W-1:LSHIFT];
  assign in_set  = in_line[SET_W-1:0] & SET_MASK;

  // apb register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == sact_pkg::CFG_IDX_LFSR_SEED) ? seed_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= sact_pkg::LFSR_SEED_RST;
    end else if (cfg_wr && paddr[2] == sact_pkg::CFG_IDX_LFSR_SEED) begin
      seed_r <= pwdata;
    end
  end

  // way compare, first matching way wins
  always_comb begin
    hit_any = 1'b0;
    hit_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_any && row_rd[w*EW + LW + 1] && row_rd[w*EW +: LW] == line_r) begin
        hit_any = 1'b1;
        hit_way = VW'(w);
      end
    end
  end

  // victim entry and writeback
  assign vic_ent    = row_rd[victim*EW +: EW];
  assign wb_now     = !hit_any && vic_ent[EW-1] && vic_ent[LW];
  assign victim_ext = {2'b00, victim};

  // modified row: dirty on store hit, fresh clean line on miss
  always_comb begin
    row_new = row_rd;
    for (int w = 0; w < WAYS; w++) begin
      if (hit_any && store_r && hit_way == VW'(w)) begin
        row_new[w*EW + LW] = 1'b1;
      end
      if (!hit_any && victim == VW'(w)) begin
        row_new[w*EW +: EW] = {1'b1, 1'b0, line_r};
      end
    end
  end

  // ram write: clearing pass or lookup write-back
  always_comb begin
    ram_we    = (state_r == ST_CLEAR) || commit;
    ram_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : set_r;
    ram_wdata = (state_r == ST_CLEAR) ? '0 : row_new;
  end

  // replacement unit control
  always_comb begin
    lfsr_ctl.load = cfg_wr && paddr[2] == sact_pkg::CFG_IDX_LFSR_SEED;
    lfsr_ctl.seed = pwdata;
    lfsr_ctl.prep = accept;
    lfsr_ctl.adv  = commit && !hit_any;
  end

  // counter update
  always_comb begin
    cnt_upd.en       = commit;
    cnt_upd.is_store = store_r;
    cnt_upd.miss     = !hit_any;
    cnt_upd.wb       = wb_now;
    cnt_upd.nbytes   = bytes_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (clr_cnt_r == SET_LAST) state_nxt = ST_IDLE;
      ST_IDLE:   if (accept) state_nxt = ST_LOOKUP;
      ST_LOOKUP: if (commit) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // control state and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
        hit_r       <= hit_any;
        victim_r    <= hit_any ? '0 : victim_ext[1:0];
        wb_r        <= wb_now;
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (accept) begin
      line_r  <= in_line;
      set_r   <= in_set;
      store_r <= in_item.is_store;
      bytes_r <= in_item.access_bytes;
    end
  end

  sact_tag_ram #(
    .DEPTH (SETS),
    .WIDTH (ROW_W),
    .AW    (SET_W)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_set),
    .rdata (row_rd)
  );

  sact_victim #(
    .WAYS (WAYS),
    .VW   (VW)
  ) u_victim (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (lfsr_ctl),
    .victim (victim)
  );

  sact_counters u_counters (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (cnt_upd),
    .cnt   (cnt)
  );

  // result channel
  assign out_item.valid               = out_valid_r;
  assign out_item.hit                 = hit_r;
  assign out_item.victim_way          = victim_r;
  assign out_item.writeback           = wb_r;
  assign out_item.read_count          = cnt.rd;
  assign out_item.read_miss_count     = cnt.rd_miss;
  assign out_item.write_count         = cnt.wr;
  assign out_item.write_miss_count    = cnt.wr_miss;
  assign out_item.bytes_read_count    = cnt.bytes_rd;
  assign out_item.bytes_written_count = cnt.bytes_wr;
  assign out_item.writeback_count     = cnt.wb;

endmodule

// File: hw/rtl/sact_tag_ram.sv
module sact_tag_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 240,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/sact_victim.sv
module sact_victim #(
  parameter int WAYS = 4,
  parameter int VW   = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sact_pkg::lfsr_ctl_t ctl,
  output logic [VW-1:0]       victim
);

  localparam longint unsigned RECIP_FULL = 64'h1_0000_0000 / WAYS;
  localparam logic [32:0]     RECIP      = 33'(RECIP_FULL);
  localparam logic [36:0]     WAYS_C     = 37'(WAYS);

  logic [sact_pkg::LFSR_W-1:0] lfsr_r;
  logic [sact_pkg::LFSR_W-1:0] cand_r;
  logic [31:0]                 q_r;
  logic [sact_pkg::LFSR_W-1:0] lfsr_step;
  logic [64:0]                 prod;
  logic [36:0]                 qw;
  logic [36:0]                 rem_est;
  logic [36:0]                 rem;

  // galois step and reciprocal quotient estimate
  always_comb begin
    lfsr_step = {1'b0, lfsr_r[sact_pkg::LFSR_W-1:1]}
              ^ (lfsr_r[0] ? sact_pkg::LFSR_TAPS : '0);
    prod      = {33'd0, lfsr_step} * {32'd0, RECIP};
  end

  // remainder from the registered estimate, one correction
  always_comb begin
    qw      = {5'd0, q_r} * WAYS_C;
    rem_est = {5'd0, cand_r} - qw;
    rem     = (rem_est >= WAYS_C) ? rem_est - WAYS_C : rem_est;
    victim  = rem[VW-1:0];
  end

  // lfsr state, seed load and candidate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= sact_pkg::LFSR_SEED_RST;
    end else if (ctl.load) begin
      lfsr_r <= ctl.seed;
    end else if (ctl.adv) begin
      lfsr_r <= cand_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.prep) begin
      cand_r <= lfsr_step;
      q_r    <= prod[63:32];
    end
  end

endmodule

// File: hw/rtl/sact_counters.sv
module sact_counters (
  input  logic                clk,
  input  logic                rst_n,
  input  sact_pkg::cnt_upd_t  upd,
  output sact_pkg::cnt_set_t  cnt
);

  sact_pkg::cnt_set_t cnt_r;
  sact_pkg::cnt_set_t cnt_nxt;

  function automatic logic [sact_pkg::CNT_W-1:0] sat_inc(
    input logic [sact_pkg::CNT_W-1:0] c
  );
    return (c == sact_pkg::CNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic logic [sact_pkg::CNT_W-1:0] sat_add(
    input logic [sact_pkg::CNT_W-1:0]   c,
    input logic [sact_pkg::BYTES_W-1:0] n
  );
    logic [sact_pkg::CNT_W:0] s;
    s = {1'b0, c} + {{(sact_pkg::CNT_W + 1 - sact_pkg::BYTES_W){1'b0}}, n};
    return s[sact_pkg::CNT_W] ? sact_pkg::CNT_MAX : s[sact_pkg::CNT_W-1:0];
  endfunction

  // next counter values
  always_comb begin
    cnt_nxt = cnt_r;
    if (upd.en) begin
      if (upd.is_store) begin
        cnt_nxt.wr       = sat_inc(cnt_r.wr);
        cnt_nxt.bytes_wr = sat_add(cnt_r.bytes_wr, upd.nbytes);
        if (upd.miss) begin
          cnt_nxt.wr_miss = sat_inc(cnt_r.wr_miss);
        end
      end else begin
        cnt_nxt.rd       = sat_inc(cnt_r.rd);
        cnt_nxt.bytes_rd = sat_add(cnt_r.bytes_rd, upd.nbytes);
        if (upd.miss) begin
          cnt_nxt.rd_miss = sat_inc(cnt_r.rd_miss);
        end
      end
      if (upd.wb) begin
        cnt_nxt.wb = sat_inc(cnt_r.wb);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign cnt = cnt_r;

endmodule

// File: hw/rtl/sact_checker.sv
module sact_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              hit,
  input logic [sact_pkg::VICTIM_W-1:0]     victim_way,
  input logic                              writeback,
  input logic [sact_pkg::CNT_W-1:0]        read_count,
  input logic [sact_pkg::CNT_W-1:0]        read_miss_count,
  input logic [sact_pkg::CNT_W-1:0]        write_count,
  input logic [sact_pkg::CNT_W-1:0]        write_miss_count,
  input logic [sact_pkg::CNT_W-1:0]        writeback_count
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(read_count)
      && $stable(write_count) && $stable(writeback_count))
    else $error("result changed while stalled");

  // reset empties the output and starts the clearing pass
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("output valid or input ready right after reset");

  // a hit replaces nothing
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && hit |-> victim_way == '0 && !writeback)
    else $error("hit reports a victim or writeback");

  // misses never outnumber accesses, writebacks never outnumber misses
  a_cnt_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> read_miss_count <= read_count && write_miss_count <= write_count
      && {1'b0, writeback_count} <= {1'b0, read_miss_count} + {1'b0, write_miss_count})
    else $error("counter ordering broken");

endmodule

bind set_assoc_cache_tag_model sact_checker u_sact_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_item.ready),
  .out_valid        (out_item.valid),
  .out_ready        (out_item.ready),
  .hit              (out_item.hit),
  .victim_way       (out_item.victim_way),
  .writeback        (out_item.writeback),
  .read_count       (out_item.read_count),
  .read_miss_count  (out_item.read_miss_count),
  .write_count      (out_item.write_count),
  .write_miss_count (out_item.write_miss_count),
  .writeback_count  (out_item.writeback_count)
);
